>>> rtl/core/wafc_pkg.sv
package wafc_pkg;

    // Field widths of the request and the result.
    localparam int MAC_W  = 48;
    localparam int HASH_W = 28;
    localparam int TIME_W = 64;
    localparam int SECS_W = 32;
    localparam int CFG_W  = 16;
    localparam int TYPE_W = 2;

    // Address mixing: six bytes, each folded in after a four-bit shift.
    localparam int MIX_BYTES = 6;
    localparam int MIX_SHIFT = 4;

    // Default width kept of the interval register.
    localparam int INTERVAL_BITS_DEF = 16;

    // Frame type code of a data frame.
    localparam logic [TYPE_W-1:0] FT_DATA = 2'd2;

    // Classification of one frame, carried alongside the interval alignment.
    typedef struct packed {
        logic              accepted;
        logic              adhoc_mode;
        logic              upload;
        logic [MAC_W-1:0]  ap_mac;
        logic [MAC_W-1:0]  client_mac;
        logic [HASH_W-1:0] bucket_hash;
    } t_flow_info;

    // Byte mix of one address, most significant byte first. The value never
    // grows past 28 bits, so the rotate of the wider form reduces to a shift.
    function automatic logic [HASH_W-1:0] mac_mix(input logic [MAC_W-1:0] mac);
        logic [HASH_W-1:0] m;
        int                k;
        m = '0;
        for (k = MIX_BYTES - 1; k >= 0; k--) begin
            m = (m << MIX_SHIFT) ^ {{(HASH_W-8){1'b0}}, mac[8*k +: 8]};
        end
        return m;
    endfunction

endpackage

>>> rtl/core/wafc_align_pipe.sv
module wafc_align_pipe #(
    parameter int DIV_W = wafc_pkg::CFG_W
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [wafc_pkg::SECS_W-1:0]     i_secs,
    input  wafc_pkg::t_flow_info            i_info,
    input  logic [DIV_W-1:0]                i_divisor,
    output logic                            o_valid,
    output wafc_pkg::t_flow_info            o_info,
    output logic [wafc_pkg::TIME_W-1:0]     o_start
);

    localparam int N = wafc_pkg::SECS_W;

    // Stage 0 is the input register; stage k+1 has taken k+1 bits of the
    // seconds into the running remainder.
    logic                          r_valid [0:N];
    logic [wafc_pkg::SECS_W-1:0]   r_secs  [0:N];
    logic [DIV_W-1:0]              r_rem   [0:N];
    wafc_pkg::t_flow_info          r_info  [0:N];
    logic [DIV_W-1:0]              n_rem   [0:N-1];

    logic                          r_out_valid;
    wafc_pkg::t_flow_info          r_out_info;
    logic [wafc_pkg::TIME_W-1:0]   r_out_start;
    logic [wafc_pkg::SECS_W-1:0]   n_aligned;
    logic [wafc_pkg::TIME_W-1:0]   n_start;

    // One restoring remainder step per stage, most significant second first.
    always_comb begin
        logic [DIV_W:0] t;
        t = '0;
        for (int k = 0; k < N; k++) begin
            t = {r_rem[k], r_secs[k][N-1-k]};
            if (t >= {1'b0, i_divisor}) begin
                n_rem[k] = DIV_W'(t - {1'b0, i_divisor});
            end else begin
                n_rem[k] = t[DIV_W-1:0];
            end
        end
    end

    // Valid bits of the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= N; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else begin
            r_valid[0] <= i_valid;
            for (int k = 0; k < N; k++) begin
                r_valid[k+1] <= r_valid[k];
            end
        end
    end

    // Payload of the stages.
    always_ff @(posedge i_clk) begin
        r_secs[0] <= i_secs;
        r_rem[0]  <= '0;
        r_info[0] <= i_info;
        for (int k = 0; k < N; k++) begin
            r_secs[k+1] <= r_secs[k];
            r_rem[k+1]  <= n_rem[k];
            r_info[k+1] <= r_info[k];
        end
    end

    // Record start is the seconds less the remainder; a rejected frame gives zero.
    always_comb begin
        n_aligned = r_secs[N] - {{(wafc_pkg::SECS_W-DIV_W){1'b0}}, r_rem[N]};
        if (r_info[N].accepted) begin
            n_start = {n_aligned, {(wafc_pkg::TIME_W-wafc_pkg::SECS_W){1'b0}}};
        end else begin
            n_start = '0;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_valid[N];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_info  <= r_info[N];
        r_out_start <= n_start;
    end

    assign o_valid = r_out_valid;
    assign o_info  = r_out_info;
    assign o_start = r_out_start;

`ifndef SYNTHESIS
    // The divisor never reads as zero.
    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_divisor != '0)
        else $error("divisor is zero");

    // The finished remainder lies below the divisor.
    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[N] |-> (r_rem[N] < i_divisor))
        else $error("remainder not below divisor");

    // A rejected frame leaves a zero record start.
    a_rejected_start_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_info.accepted) |-> (r_out_start == '0))
        else $error("rejected frame has a record start");
`endif

endmodule

>>> rtl/core/wlan_assoc_flow_classifier.sv
// A request passes the input register, the remainder stages and the output register.
// Throughput: one request per cycle; busy stays low, as the 32-stage remainder
// pipeline (one seconds bit per stage) takes a new request at every edge.
// The receiver cannot stall; each result shows for one cycle with o_strobe high.
// Synchronous active-low reset clears all stage valid bits and sets the interval to 1.
module wlan_assoc_flow_classifier #(
    parameter int INTERVAL_BITS = wafc_pkg::INTERVAL_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_cfg_we,
    input  logic [wafc_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic [wafc_pkg::TYPE_W-1:0]     i_frame_type,
    input  logic                            i_to_ds,
    input  logic                            i_from_ds,
    input  logic [wafc_pkg::MAC_W-1:0]      i_address_one,
    input  logic [wafc_pkg::MAC_W-1:0]      i_address_two,
    input  logic [wafc_pkg::MAC_W-1:0]      i_address_three,
    input  logic [wafc_pkg::MAC_W-1:0]      i_address_four,
    input  logic [wafc_pkg::TIME_W-1:0]     i_pkt_time,
    output logic                            o_strobe,
    output logic                            o_accepted,
    output logic                            o_adhoc_mode,
    output logic                            o_upload,
    output logic [wafc_pkg::MAC_W-1:0]      o_ap_mac,
    output logic [wafc_pkg::MAC_W-1:0]      o_client_mac,
    output logic [wafc_pkg::HASH_W-1:0]     o_bucket_hash,
    output logic [wafc_pkg::TIME_W-1:0]     o_record_start
);

    // Interval bits kept: the register never holds more than the write data.
    localparam int DIV_W = (INTERVAL_BITS < wafc_pkg::CFG_W) ? INTERVAL_BITS : wafc_pkg::CFG_W;

    logic [DIV_W-1:0]               r_interval;
    logic [DIV_W-1:0]               divisor;
    logic                           accept;
    logic                           is_adhoc;
    logic                           lower_three;
    logic [wafc_pkg::MAC_W-1:0]     mix_a;
    logic [wafc_pkg::MAC_W-1:0]     mix_b;
    wafc_pkg::t_flow_info           info;
    wafc_pkg::t_flow_info           out_info;

    // The pipeline never stalls, so a request is always taken.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Interval register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= DIV_W'(1);
        end else if (i_cfg_we) begin
            r_interval <= i_cfg_wdata[DIV_W-1:0];
        end
    end

    // An interval of zero behaves as one second.
    assign divisor = (r_interval == '0) ? DIV_W'(1) : r_interval;

    // Direction, canonical addresses and bucket hash of the request.
    always_comb begin
        is_adhoc    = !i_to_ds && !i_from_ds;
        lower_three = i_address_three < i_address_four;
        mix_a       = is_adhoc ? i_address_three : i_address_one;
        mix_b       = is_adhoc ? i_address_four  : i_address_two;
        info        = '0;
        if (i_frame_type == wafc_pkg::FT_DATA) begin
            info.accepted    = 1'b1;
            info.adhoc_mode  = is_adhoc;
            info.bucket_hash = wafc_pkg::mac_mix(mix_a) ^ wafc_pkg::mac_mix(mix_b);
            if (is_adhoc) begin
                info.upload     = lower_three;
                info.ap_mac     = lower_three ? i_address_three : i_address_four;
                info.client_mac = lower_three ? i_address_four  : i_address_three;
            end else if (i_from_ds) begin
                info.upload     = 1'b0;
                info.ap_mac     = i_address_two;
                info.client_mac = i_address_one;
            end else begin
                info.upload     = 1'b1;
                info.ap_mac     = i_address_one;
                info.client_mac = i_address_two;
            end
        end
    end

    // Record start alignment, with the classification riding alongside.
    wafc_align_pipe #(
        .DIV_W (DIV_W)
    ) u_align (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (accept),
        .i_secs    (i_pkt_time[wafc_pkg::TIME_W-1 -: wafc_pkg::SECS_W]),
        .i_info    (info),
        .i_divisor (divisor),
        .o_valid   (o_strobe),
        .o_info    (out_info),
        .o_start   (o_record_start)
    );

    assign o_accepted    = out_info.accepted;
    assign o_adhoc_mode  = out_info.adhoc_mode;
    assign o_upload      = out_info.upload;
    assign o_ap_mac      = out_info.ap_mac;
    assign o_client_mac  = out_info.client_mac;
    assign o_bucket_hash = out_info.bucket_hash;

`ifndef SYNTHESIS
    // An ad hoc pair is ordered, and an upload pair is strictly ordered.
    a_adhoc_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_adhoc_mode) |->
            ((o_ap_mac <= o_client_mac) && (!o_upload || (o_ap_mac < o_client_mac))))
        else $error("ad hoc pair out of order");

    // The record start never carries fraction bits.
    a_start_whole_seconds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_record_start[wafc_pkg::SECS_W-1:0] == '0))
        else $error("record start has fraction bits");

    // A rejected frame gives an all-zero result.
    a_rejected_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_accepted) |->
            (!o_adhoc_mode && !o_upload && (o_ap_mac == '0) && (o_client_mac == '0)
             && (o_bucket_hash == '0)))
        else $error("rejected frame has non-zero fields");
`endif

endmodule

>>> tb/wafc_flow_checker.sv
`timescale 1ns / 1ps

// Watches the request, configuration and result ports of the flow classifier,
// predicts each result from the accepted request and compares it field by field.
module wafc_flow_checker #(
    parameter int INTERVAL_BITS = wafc_pkg::INTERVAL_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic                            i_busy,
    input  logic                            i_cfg_we,
    input  logic [wafc_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic [wafc_pkg::TYPE_W-1:0]     i_frame_type,
    input  logic                            i_to_ds,
    input  logic                            i_from_ds,
    input  logic [wafc_pkg::MAC_W-1:0]      i_address_one,
    input  logic [wafc_pkg::MAC_W-1:0]      i_address_two,
    input  logic [wafc_pkg::MAC_W-1:0]      i_address_three,
    input  logic [wafc_pkg::MAC_W-1:0]      i_address_four,
    input  logic [wafc_pkg::TIME_W-1:0]     i_pkt_time,
    input  logic                            i_strobe,
    input  logic                            i_accepted,
    input  logic                            i_adhoc_mode,
    input  logic                            i_upload,
    input  logic [wafc_pkg::MAC_W-1:0]      i_ap_mac,
    input  logic [wafc_pkg::MAC_W-1:0]      i_client_mac,
    input  logic [wafc_pkg::HASH_W-1:0]     i_bucket_hash,
    input  logic [wafc_pkg::TIME_W-1:0]     i_record_start,
    output int                              o_pending,
    output int                              o_mismatches
);

    import wafc_pkg::*;

    // Only the low INTERVAL_BITS bits of a written interval are kept.
    localparam logic [CFG_W-1:0] INTERVAL_KEEP =
        (INTERVAL_BITS >= CFG_W) ? {CFG_W{1'b1}} : CFG_W'((32'd1 << INTERVAL_BITS) - 1);

    typedef struct packed {
        logic              accepted;
        logic              adhoc_mode;
        logic              upload;
        logic [MAC_W-1:0]  ap_mac;
        logic [MAC_W-1:0]  client_mac;
        logic [HASH_W-1:0] bucket_hash;
        logic [TIME_W-1:0] record_start;
    } t_flow_result;

    t_flow_result     pending_flows[$];
    logic [CFG_W-1:0] interval_reg;
    int               mismatch_count = 0;

    // Each address byte lands four bits further up than the next less
    // significant one, so the whole fold is an xor of shifted bytes.
    function automatic logic [HASH_W-1:0] fold_address(input logic [MAC_W-1:0] mac);
        logic [HASH_W-1:0] acc;
        int                i;
        acc = '0;
        for (i = 0; i < MIX_BYTES; i++) begin
            acc ^= HASH_W'(mac[8*i +: 8]) << (MIX_SHIFT * i);
        end
        return acc;
    endfunction

    // Expected result of one frame header under the given interval.
    function automatic t_flow_result classify_frame(
        input logic [TYPE_W-1:0] ftype,
        input logic              to_ds,
        input logic              from_ds,
        input logic [MAC_W-1:0]  a1,
        input logic [MAC_W-1:0]  a2,
        input logic [MAC_W-1:0]  a3,
        input logic [MAC_W-1:0]  a4,
        input logic [TIME_W-1:0] stamp,
        input logic [CFG_W-1:0]  interval
    );
        t_flow_result             r;
        logic [SECS_W-1:0]        secs;
        logic [SECS_W-1:0]        span;
        r = '0;
        if (ftype != FT_DATA) begin
            return r;
        end
        r.accepted = 1'b1;
        if (!to_ds && !from_ds) begin
            // Ad hoc pair: the lower address plays the access point.
            r.adhoc_mode  = 1'b1;
            r.bucket_hash = fold_address(a3) ^ fold_address(a4);
            if (a3 < a4) begin
                r.upload     = 1'b1;
                r.ap_mac     = a3;
                r.client_mac = a4;
            end else begin
                r.ap_mac     = a4;
                r.client_mac = a3;
            end
        end else if (from_ds) begin
            // Both bits set falls here as well.
            r.bucket_hash = fold_address(a1) ^ fold_address(a2);
            r.ap_mac      = a2;
            r.client_mac  = a1;
        end else begin
            r.bucket_hash = fold_address(a1) ^ fold_address(a2);
            r.upload      = 1'b1;
            r.ap_mac      = a1;
            r.client_mac  = a2;
        end
        // A zero interval behaves as one second.
        span = (interval == '0) ? SECS_W'(1) : SECS_W'(interval);
        secs = stamp[TIME_W-1 -: SECS_W];
        r.record_start = {secs - (secs % span), {(TIME_W-SECS_W){1'b0}}};
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [TIME_W-1:0] got,
                                   input logic [TIME_W-1:0] want);
        mismatch_count++;
        $display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, want);
    endtask

    // Results are checked before the request of the same edge is queued; the
    // pipeline is far too long for the two to belong together.
    always @(posedge i_clk) begin
        t_flow_result seen;
        t_flow_result want;
        if (!i_rst_n) begin
            interval_reg = CFG_W'(1);
            pending_flows.delete();
        end else begin
            if (i_strobe) begin
                seen = '{i_accepted, i_adhoc_mode, i_upload, i_ap_mac, i_client_mac,
                         i_bucket_hash, i_record_start};
                if (pending_flows.size() == 0) begin
                    report_mismatch("unrequested result", '0, '0);
                end else begin
                    want = pending_flows.pop_front();
                    if (seen.accepted != want.accepted)
                        report_mismatch("accepted", TIME_W'(seen.accepted),
                                        TIME_W'(want.accepted));
                    if (seen.adhoc_mode != want.adhoc_mode)
                        report_mismatch("adhoc_mode", TIME_W'(seen.adhoc_mode),
                                        TIME_W'(want.adhoc_mode));
                    if (seen.upload != want.upload)
                        report_mismatch("upload", TIME_W'(seen.upload),
                                        TIME_W'(want.upload));
                    if (seen.ap_mac != want.ap_mac)
                        report_mismatch("ap_mac", TIME_W'(seen.ap_mac),
                                        TIME_W'(want.ap_mac));
                    if (seen.client_mac != want.client_mac)
                        report_mismatch("client_mac", TIME_W'(seen.client_mac),
                                        TIME_W'(want.client_mac));
                    if (seen.bucket_hash != want.bucket_hash)
                        report_mismatch("bucket_hash", TIME_W'(seen.bucket_hash),
                                        TIME_W'(want.bucket_hash));
                    if (seen.record_start != want.record_start)
                        report_mismatch("record_start", seen.record_start,
                                        want.record_start);
                end
            end
            if (i_start && !i_busy) begin
                pending_flows.push_back(classify_frame(
                    i_frame_type, i_to_ds, i_from_ds, i_address_one, i_address_two,
                    i_address_three, i_address_four, i_pkt_time, interval_reg));
            end
            if (i_cfg_we) begin
                interval_reg = i_cfg_wdata & INTERVAL_KEEP;
            end
        end
        o_pending    <= pending_flows.size();
        o_mismatches <= mismatch_count;
    end

endmodule

>>> tb/tb_wlan_assoc_flow_classifier.sv
`timescale 1ns / 1ps

// Drives frame header requests into the classifier and gives the verdict; the
// checker beside the block does all prediction and comparison.
module tb_wlan_assoc_flow_classifier;

    import wafc_pkg::*;

    // Frame type codes other than data.
    localparam logic [TYPE_W-1:0] FT_MGMT = 2'd0;
    localparam logic [TYPE_W-1:0] FT_CTRL = 2'd1;
    localparam logic [TYPE_W-1:0] FT_EXT  = 2'd3;

    localparam logic [MAC_W-1:0]  MAC_ONES  = {MAC_W{1'b1}};
    localparam logic [TIME_W-1:0] TIME_ONES = {TIME_W{1'b1}};
    localparam int ITEMS_PER_PHASE = 160;
    localparam int SETTLE_CYCLES   = 40;

    typedef struct {
        logic [TYPE_W-1:0] ftype;
        logic              to_ds;
        logic              from_ds;
        logic [MAC_W-1:0]  a1;
        logic [MAC_W-1:0]  a2;
        logic [MAC_W-1:0]  a3;
        logic [MAC_W-1:0]  a4;
        logic [TIME_W-1:0] stamp;
    } t_frame_req;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_cfg_we;
    logic [CFG_W-1:0]   i_cfg_wdata;
    logic [TYPE_W-1:0]  i_frame_type;
    logic               i_to_ds;
    logic               i_from_ds;
    logic [MAC_W-1:0]   i_address_one;
    logic [MAC_W-1:0]   i_address_two;
    logic [MAC_W-1:0]   i_address_three;
    logic [MAC_W-1:0]   i_address_four;
    logic [TIME_W-1:0]  i_pkt_time;
    logic               o_strobe;
    logic               o_accepted;
    logic               o_adhoc_mode;
    logic               o_upload;
    logic [MAC_W-1:0]   o_ap_mac;
    logic [MAC_W-1:0]   o_client_mac;
    logic [HASH_W-1:0]  o_bucket_hash;
    logic [TIME_W-1:0]  o_record_start;
    int                 flows_pending;
    int                 mismatches;

    wlan_assoc_flow_classifier u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_frame_type    (i_frame_type),
        .i_to_ds         (i_to_ds),
        .i_from_ds       (i_from_ds),
        .i_address_one   (i_address_one),
        .i_address_two   (i_address_two),
        .i_address_three (i_address_three),
        .i_address_four  (i_address_four),
        .i_pkt_time      (i_pkt_time),
        .o_strobe        (o_strobe),
        .o_accepted      (o_accepted),
        .o_adhoc_mode    (o_adhoc_mode),
        .o_upload        (o_upload),
        .o_ap_mac        (o_ap_mac),
        .o_client_mac    (o_client_mac),
        .o_bucket_hash   (o_bucket_hash),
        .o_record_start  (o_record_start)
    );

    wafc_flow_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_frame_type    (i_frame_type),
        .i_to_ds         (i_to_ds),
        .i_from_ds       (i_from_ds),
        .i_address_one   (i_address_one),
        .i_address_two   (i_address_two),
        .i_address_three (i_address_three),
        .i_address_four  (i_address_four),
        .i_pkt_time      (i_pkt_time),
        .i_strobe        (o_strobe),
        .i_accepted      (o_accepted),
        .i_adhoc_mode    (o_adhoc_mode),
        .i_upload        (o_upload),
        .i_ap_mac        (o_ap_mac),
        .i_client_mac    (o_client_mac),
        .i_bucket_hash   (o_bucket_hash),
        .i_record_start  (o_record_start),
        .o_pending       (flows_pending),
        .o_mismatches    (mismatches)
    );

    // Clock generation.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Safety net against a hung handshake or lost results.
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic t_frame_req make_frame(
        input logic [TYPE_W-1:0] ftype, input logic to_ds, input logic from_ds,
        input logic [MAC_W-1:0] a1, input logic [MAC_W-1:0] a2,
        input logic [MAC_W-1:0] a3, input logic [MAC_W-1:0] a4,
        input logic [TIME_W-1:0] stamp
    );
        t_frame_req f;
        f = '{ftype, to_ds, from_ds, a1, a2, a3, a4, stamp};
        return f;
    endfunction

    // Mostly random addresses, with the all-zero and all-one extremes mixed in.
    function automatic logic [MAC_W-1:0] pick_address();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return MAC_ONES;
            default: return MAC_W'({$urandom, $urandom});
        endcase
    endfunction

    // Presents one request and holds it until accepted, then idles for a
    // random number of cycles when gaps are wanted.
    task automatic send_frame(input t_frame_req f, input bit with_gaps);
        int gap;
        start           <= 1'b1;
        i_frame_type    <= f.ftype;
        i_to_ds         <= f.to_ds;
        i_from_ds       <= f.from_ds;
        i_address_one   <= f.a1;
        i_address_two   <= f.a2;
        i_address_three <= f.a3;
        i_address_four  <= f.a4;
        i_pkt_time      <= f.stamp;
        do @(posedge i_clk); while (busy);
        gap = with_gaps ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stops issuing and waits until every expected result has come back. The
    // extra edge lets the checker count the request taken at this edge.
    task automatic drain_flows();
        start <= 1'b0;
        @(posedge i_clk);
        while (flows_pending != 0) @(posedge i_clk);
    endtask

    task automatic write_interval(input logic [CFG_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Random requests under one interval: mostly data frames, with ad hoc
    // pairs often equal or close, and timestamps often on an interval boundary.
    task automatic run_random_phase(input logic [CFG_W-1:0] interval, input bit with_gaps);
        t_frame_req        f;
        logic [SECS_W-1:0] span;
        logic [SECS_W-1:0] secs;
        int                n;
        int                sel;
        span = (interval == '0) ? SECS_W'(1) : SECS_W'(interval);
        for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ($urandom_range(0, 9) == 0) begin
                sel = $urandom_range(0, 2);
                f.ftype = (sel == 0) ? FT_MGMT : (sel == 1) ? FT_CTRL : FT_EXT;
            end else begin
                f.ftype = FT_DATA;
            end
            f.to_ds   = 1'($urandom_range(0, 1));
            f.from_ds = 1'($urandom_range(0, 1));
            f.a1      = pick_address();
            f.a2      = pick_address();
            f.a3      = pick_address();
            case ($urandom_range(0, 9))
                0, 1:    f.a4 = f.a3;
                2, 3:    f.a4 = f.a3 ^ MAC_W'($urandom_range(1, 255));
                default: f.a4 = pick_address();
            endcase
            case ($urandom_range(0, 9))
                0: f.stamp = '0;
                1: f.stamp = TIME_ONES;
                2: begin
                    secs    = ($urandom / span) * span;
                    f.stamp = {secs, $urandom};
                end
                3: begin
                    secs    = ($urandom / span) * span + span - 1;
                    f.stamp = {secs, $urandom};
                end
                default: f.stamp = {$urandom, $urandom};
            endcase
            send_frame(f, with_gaps);
        end
        drain_flows();
    endtask

    // Main sequence.
    initial begin
        logic [CFG_W-1:0] phase_interval[5];
        int               p;
        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_wdata     <= '0;
        i_frame_type    <= FT_MGMT;
        i_to_ds         <= 1'b0;
        i_from_ds       <= 1'b0;
        i_address_one   <= '0;
        i_address_two   <= '0;
        i_address_three <= '0;
        i_address_four  <= '0;
        i_pkt_time      <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests under the reset interval of one second.
        send_frame(make_frame(FT_MGMT, 1'b1, 1'b1, MAC_ONES, MAC_ONES, MAC_ONES, MAC_ONES,
                              TIME_ONES), 1'b1);
        send_frame(make_frame(FT_CTRL, 1'b0, 1'b0, MAC_ONES, '0, MAC_ONES, '0, TIME_ONES),
                   1'b1);
        send_frame(make_frame(FT_EXT, 1'b1, 1'b0, 48'h0123_4567_89ab, 48'hfedc_ba98_7654,
                              '0, MAC_ONES, 64'h1234_5678_9abc_def0), 1'b0);
        send_frame(make_frame(FT_DATA, 1'b1, 1'b0, '0, MAC_ONES, '0, '0, '0), 1'b0);
        send_frame(make_frame(FT_DATA, 1'b0, 1'b1, MAC_ONES, '0, '0, '0, TIME_ONES), 1'b1);
        send_frame(make_frame(FT_DATA, 1'b1, 1'b1, 48'h0011_2233_4455, 48'h6677_8899_aabb,
                              MAC_ONES, '0, 64'h0000_0001_ffff_ffff), 1'b0);
        send_frame(make_frame(FT_DATA, 1'b0, 1'b0, '0, '0, 48'h0000_0000_0001,
                              48'h0000_0000_0002, 64'h8000_0000_0000_0000), 1'b1);
        send_frame(make_frame(FT_DATA, 1'b0, 1'b0, '0, '0, 48'h0000_0000_0002,
                              48'h0000_0000_0001, 64'h7fff_ffff_8000_0000), 1'b0);
        send_frame(make_frame(FT_DATA, 1'b0, 1'b0, MAC_ONES, MAC_ONES, 48'h5a5a_5a5a_5a5a,
                              48'h5a5a_5a5a_5a5a, 64'h0000_0003_0000_0001), 1'b1);
        send_frame(make_frame(FT_DATA, 1'b0, 1'b0, '0, '0, '0, MAC_ONES, TIME_ONES), 1'b0);
        send_frame(make_frame(FT_DATA, 1'b0, 1'b0, '0, '0, MAC_ONES, '0, '0), 1'b0);
        send_frame(make_frame(FT_DATA, 1'b1, 1'b0, 48'haaaa_aaaa_aaaa, 48'h5555_5555_5555,
                              48'h5555_5555_5555, 48'haaaa_aaaa_aaaa,
                              64'haaaa_aaaa_5555_5555), 1'b1);
        send_frame(make_frame(FT_DATA, 1'b0, 1'b1, 48'h5555_5555_5555, 48'haaaa_aaaa_aaaa,
                              '0, '0, 64'h5555_5555_aaaa_aaaa), 1'b0);
        drain_flows();

        // Random phases over several intervals, including zero and the maximum;
        // every other phase runs without idle gaps.
        phase_interval[0] = '0;
        phase_interval[1] = {CFG_W{1'b1}};
        phase_interval[2] = CFG_W'($urandom_range(2, 60));
        phase_interval[3] = CFG_W'($urandom_range(1, 65535));
        phase_interval[4] = CFG_W'(1);
        for (p = 0; p < 5; p++) begin
            write_interval(phase_interval[p]);
            run_random_phase(phase_interval[p], (p % 2) == 0);
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && flows_pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
